FILE: hw/rtl/bbrr_pkg.sv
// ----------------------------------------------------------------------------
// bbrr_pkg
// Shared types, constants and helpers for the byte buffer range-reverse block.
// ----------------------------------------------------------------------------
package bbrr_pkg;

  // Buffer geometry.
  localparam int BUFFER_DEPTH = 1024;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // Fixed field widths of the command and response transactions.
  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int BYTE_W  = 8;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Command codes.
  localparam op_t OP_WRITE   = 2'd0;
  localparam op_t OP_READ    = 2'd1;
  localparam op_t OP_REVERSE = 2'd2;

  // True when an index names an entry of the buffer.
  function automatic logic in_range(input index_t idx);
    return (32'(idx) < 32'(BUFFER_DEPTH));
  endfunction

endpackage

FILE: hw/rtl/bbrr_if.sv
// ----------------------------------------------------------------------------
// bbrr_cmd_if / bbrr_rsp_if
// Valid/ready channels for commands into and read results out of the buffer.
// ----------------------------------------------------------------------------

// Command channel: one transaction carries one write, read or reverse.
interface bbrr_cmd_if;
  logic              valid;
  logic              ready;
  bbrr_pkg::op_t     operation;
  bbrr_pkg::index_t  first_index;
  bbrr_pkg::index_t  last_index;
  bbrr_pkg::byte_t   byte_value;

  modport source (output valid, output operation, output first_index,
                  output last_index, output byte_value, input ready);
  modport sink   (input valid, input operation, input first_index,
                  input last_index, input byte_value, output ready);
endinterface

// Response channel: one transaction per read command.
interface bbrr_rsp_if;
  logic              valid;
  logic              ready;
  bbrr_pkg::byte_t   read_byte;
  bbrr_pkg::index_t  read_position;

  modport source (output valid, output read_byte, output read_position, input ready);
  modport sink   (input valid, input read_byte, input read_position, output ready);
endinterface

FILE: hw/rtl/byte_buffer_range_reverse.sv
// ----------------------------------------------------------------------------
// byte_buffer_range_reverse
// Byte buffer with single-byte write, single-byte read and in-place reverse.
// ----------------------------------------------------------------------------
// The buffer lives in one synchronous memory with one write port and one
// registered read port. After reset the block clears all BUFFER_DEPTH (1024)
// entries of the memory with ready low. A read passes through the memory's
// read register and then the output register, from which the result is
// taken. The command input stays stalled while a result waits in that
// register, so a held-off response blocks every command behind it. In a
// reverse over first..last each pair swap reads the low byte, reads the high
// byte, writes the low entry and writes the high entry, with the next low
// read overlapped on the high write, so the read latency and the single
// write port set the pace. A reverse with first at or above last, or an end
// outside the buffer, changes nothing.
module byte_buffer_range_reverse (
  input  logic        clk,
  input  logic        rst,
  bbrr_cmd_if.sink    cmd,
  bbrr_rsp_if.source  rsp
);

  // Controller states.
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_RD_HI  = 3'd3;
  localparam logic [2:0] ST_WR_LO  = 3'd4;
  localparam logic [2:0] ST_WR_HI  = 3'd5;

  localparam bbrr_pkg::addr_t LAST_ADDR = bbrr_pkg::ADDR_W'(bbrr_pkg::BUFFER_DEPTH - 1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  bbrr_pkg::addr_t   clr_addr;
  bbrr_pkg::addr_t   lo;
  bbrr_pkg::addr_t   hi;
  bbrr_pkg::byte_t   lo_byte;
  bbrr_pkg::index_t  rd_pos;
  logic              rd_oor;
  logic              out_valid;
  bbrr_pkg::byte_t   out_byte;
  bbrr_pkg::index_t  out_pos;

  // Memory and its ports.
  bbrr_pkg::byte_t   mem [bbrr_pkg::BUFFER_DEPTH];
  logic              wr_en;
  bbrr_pkg::addr_t   wr_addr;
  bbrr_pkg::byte_t   wr_data;
  logic              rd_en;
  bbrr_pkg::addr_t   rd_addr;
  bbrr_pkg::byte_t   rd_data;

  logic              accept;
  bbrr_pkg::addr_t   cmd_first;
  bbrr_pkg::addr_t   cmd_last;
  logic              rev_go;
  logic [bbrr_pkg::ADDR_W:0] lo_plus2;
  logic              more_pairs;

  // Command decode.
  assign cmd.ready  = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept     = cmd.valid && cmd.ready;
  assign cmd_first  = bbrr_pkg::ADDR_W'(cmd.first_index);
  assign cmd_last   = bbrr_pkg::ADDR_W'(cmd.last_index);
  assign rev_go     = (cmd.operation == bbrr_pkg::OP_REVERSE)
                      && (cmd.first_index < cmd.last_index)
                      && bbrr_pkg::in_range(cmd.last_index);
  assign lo_plus2   = {1'b0, lo} + (bbrr_pkg::ADDR_W + 1)'(2);
  assign more_pairs = lo_plus2 < {1'b0, hi};

  // Memory port steering and next state.
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = lo;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = hi;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = cmd_first;
        wr_addr = cmd_first;
        wr_data = cmd.byte_value;
        if (accept) begin
          case (cmd.operation)
            bbrr_pkg::OP_WRITE: begin
              wr_en = bbrr_pkg::in_range(cmd.first_index);
            end
            bbrr_pkg::OP_READ: begin
              rd_en      = 1'b1;
              state_next = ST_READ;
            end
            bbrr_pkg::OP_REVERSE: begin
              if (rev_go) begin
                rd_en      = 1'b1;
                state_next = ST_RD_HI;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_RD_HI: begin
        rd_en      = 1'b1;
        rd_addr    = hi;
        state_next = ST_WR_LO;
      end
      ST_WR_LO: begin
        // Read data now holds the high byte.
        wr_en      = 1'b1;
        wr_addr    = lo;
        wr_data    = rd_data;
        state_next = ST_WR_HI;
      end
      ST_WR_HI: begin
        // Write the saved low byte high and start the next pair's low read.
        wr_en   = 1'b1;
        wr_addr = hi;
        wr_data = lo_byte;
        rd_addr = lo + bbrr_pkg::ADDR_W'(1);
        if (more_pairs) begin
          rd_en      = 1'b1;
          state_next = ST_RD_HI;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Buffer memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + bbrr_pkg::ADDR_W'(1);
      end
      if (state == ST_READ) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers for the swap loop and the read result.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      lo     <= cmd_first;
      hi     <= cmd_last;
      rd_pos <= cmd.first_index;
      rd_oor <= !bbrr_pkg::in_range(cmd.first_index);
    end
    if (state == ST_RD_HI) begin
      lo_byte <= rd_data;
    end
    if (state == ST_WR_HI) begin
      lo <= lo + bbrr_pkg::ADDR_W'(1);
      hi <= hi - bbrr_pkg::ADDR_W'(1);
    end
    if (state == ST_READ) begin
      out_byte <= rd_oor ? '0 : rd_data;
      out_pos  <= rd_pos;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_byte     = out_byte;
  assign rsp.read_position = out_pos;

endmodule

FILE: hw/rtl/bbrr_checker.sv
// ----------------------------------------------------------------------------
// bbrr_checker
// Port-level checks for the byte buffer, bound to byte_buffer_range_reverse.
// ----------------------------------------------------------------------------
module bbrr_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input bbrr_pkg::op_t     cmd_operation,
  input bbrr_pkg::index_t  cmd_first_index,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input bbrr_pkg::byte_t   rsp_read_byte,
  input bbrr_pkg::index_t  rsp_read_position
);

  logic read_taken;

  assign read_taken = cmd_valid && cmd_ready && (cmd_operation == bbrr_pkg::OP_READ);

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
                                && $stable(rsp_read_position))
    else $error("response changed while stalled");

  // Every accepted read is followed by its result on the response channel.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    read_taken |-> ##2 rsp_valid)
    else $error("read result missing");

  // A new response carries the position of the matching accepted read.
  a_read_pos: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(read_taken, 2)
                         && rsp_read_position == $past(cmd_first_index, 2))
    else $error("response without matching read");

  // The clearing pass keeps commands out right after reset.
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !cmd_ready)
    else $error("command accepted during clearing pass");

endmodule

bind byte_buffer_range_reverse bbrr_checker u_bbrr_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .cmd_operation     (cmd.operation),
  .cmd_first_index   (cmd.first_index),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_read_byte     (rsp.read_byte),
  .rsp_read_position (rsp.read_position)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte buffer range-reverse block. A mirror of the
// buffer is updated on every accepted command, and each read result is checked
// against the byte the mirror held when the read was accepted. Stimulus runs
// through directed corner cases, string-like load/reverse/print sequences
// under several idle and stall mixes, and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  // Code with no meaning to the block; it must be ignored.
  localparam bbrr_pkg::op_t OP_UNUSED = 2'd3;

  // One expected read result.
  typedef struct packed {
    bbrr_pkg::byte_t  read_byte;
    bbrr_pkg::index_t read_position;
  } read_result_t;

  logic clk;
  logic rst;

  bbrr_cmd_if cmd_bus ();
  bbrr_rsp_if rsp_bus ();

  byte_buffer_range_reverse dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  // Mirror of the buffer and the reads still owed by the block.
  bbrr_pkg::byte_t buffer_mirror [bbrr_pkg::BUFFER_DEPTH];
  read_result_t    expected_reads[$];

  int sender_idle_pct = 0;
  int rsp_stall_pct   = 0;
  bit hold_rsp        = 1'b0;
  int mismatches      = 0;
  int cmds_sent       = 0;
  int reads_checked   = 0;
  int reverses_done   = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall limit on the run.
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Response ready: random stalls, or a full hold-off while hold_rsp is set.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_bus.ready = !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Compare every accepted read result with the oldest expectation.
  always @(posedge clk) begin
    read_result_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %0h position %0d",
                                  rsp_bus.read_byte, rsp_bus.read_position));
      end else begin
        want = expected_reads.pop_front();
        reads_checked++;
        if (rsp_bus.read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte %0h, expected %0h (position %0d)",
                                    rsp_bus.read_byte, want.read_byte,
                                    want.read_position));
        if (rsp_bus.read_position !== want.read_position)
          report_mismatch($sformatf("read_position %0d, expected %0d",
                                    rsp_bus.read_position, want.read_position));
      end
    end
  end

  // Apply one accepted command to the mirror and queue any read result.
  function automatic void update_mirror(input bbrr_pkg::op_t op,
                                        input bbrr_pkg::index_t first_idx,
                                        input bbrr_pkg::index_t last_idx,
                                        input bbrr_pkg::byte_t value);
    int              lo;
    int              hi;
    bbrr_pkg::byte_t tmp;
    read_result_t    res;
    case (op)
      bbrr_pkg::OP_WRITE: begin
        if (int'(first_idx) < bbrr_pkg::BUFFER_DEPTH) buffer_mirror[first_idx] = value;
      end
      bbrr_pkg::OP_READ: begin
        res.read_byte     = (int'(first_idx) < bbrr_pkg::BUFFER_DEPTH)
                            ? buffer_mirror[first_idx] : '0;
        res.read_position = first_idx;
        expected_reads.push_back(res);
      end
      bbrr_pkg::OP_REVERSE: begin
        lo = int'(first_idx);
        hi = int'(last_idx);
        if (lo <= hi && hi < bbrr_pkg::BUFFER_DEPTH) begin
          reverses_done++;
          while (lo < hi) begin
            tmp               = buffer_mirror[lo];
            buffer_mirror[lo] = buffer_mirror[hi];
            buffer_mirror[hi] = tmp;
            lo++;
            hi--;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one command after a random gap and wait for its transaction.
  task automatic send_cmd(input bbrr_pkg::op_t op, input bbrr_pkg::index_t first_idx,
                          input bbrr_pkg::index_t last_idx,
                          input bbrr_pkg::byte_t value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    @(negedge clk);
    if (gap > 0) begin
      cmd_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid       = 1'b1;
    cmd_bus.operation   = op;
    cmd_bus.first_index = first_idx;
    cmd_bus.last_index  = last_idx;
    cmd_bus.byte_value  = value;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    update_mirror(op, first_idx, last_idx, value);
    cmds_sent++;
  endtask

  task automatic idle_cmd();
    @(negedge clk);
    cmd_bus.valid = 1'b0;
  endtask

  // Fully random command, including the unused code and inverted ranges.
  task automatic send_noise();
    send_cmd(bbrr_pkg::op_t'($urandom_range(3)),
             bbrr_pkg::index_t'($urandom_range(1023)),
             bbrr_pkg::index_t'($urandom_range(1023)),
             bbrr_pkg::byte_t'($urandom_range(255)));
  endtask

  // Load a short string, reverse part of it, then print it back.
  task automatic run_text_sequence(input int max_len);
    int len;
    int base;
    int lo;
    int hi;
    int tmp;
    len  = $urandom_range(1, max_len);
    base = $urandom_range(0, bbrr_pkg::BUFFER_DEPTH - len);
    for (int i = 0; i < len; i++)
      send_cmd(bbrr_pkg::OP_WRITE, bbrr_pkg::index_t'(base + i),
               bbrr_pkg::index_t'($urandom_range(1023)),
               bbrr_pkg::byte_t'($urandom_range(255)));
    lo = base + $urandom_range(0, len - 1);
    hi = base + $urandom_range(0, len - 1);
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    // Now and then the range arrives inverted and must be ignored.
    if ($urandom_range(9) == 0 && lo != hi)
      send_cmd(bbrr_pkg::OP_REVERSE, bbrr_pkg::index_t'(hi), bbrr_pkg::index_t'(lo),
               bbrr_pkg::byte_t'($urandom_range(255)));
    else
      send_cmd(bbrr_pkg::OP_REVERSE, bbrr_pkg::index_t'(lo), bbrr_pkg::index_t'(hi),
               bbrr_pkg::byte_t'($urandom_range(255)));
    for (int i = 0; i < len; i++)
      send_cmd(bbrr_pkg::OP_READ, bbrr_pkg::index_t'(base + i),
               bbrr_pkg::index_t'($urandom_range(1023)),
               bbrr_pkg::byte_t'($urandom_range(255)));
  endtask

  // Corner cases: buffer ends, full and degenerate reverses, unused code.
  task automatic test_directed();
    send_cmd(bbrr_pkg::OP_READ,    10'd5,    10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_WRITE,   10'd0,    10'd0,    8'hAA);
    send_cmd(bbrr_pkg::OP_WRITE,   10'd1,    10'd1023, 8'h55);
    send_cmd(bbrr_pkg::OP_WRITE,   10'd2,    10'd0,    8'hFF);
    send_cmd(bbrr_pkg::OP_WRITE,   10'd1023, 10'd1023, 8'hFF);
    send_cmd(bbrr_pkg::OP_WRITE,   10'd6,    10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd0,    10'd0,    8'hFF);
    send_cmd(bbrr_pkg::OP_READ,    10'd1023, 10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_REVERSE, 10'd0,    10'd1023, 8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd0,    10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd1023, 10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_REVERSE, 10'd1023, 10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_REVERSE, 10'd7,    10'd7,    8'h00);
    send_cmd(OP_UNUSED,            10'd1023, 10'd1023, 8'hFF);
    send_cmd(bbrr_pkg::OP_REVERSE, 10'd0,    10'd1,    8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd0,    10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd1,    10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_REVERSE, 10'd1018, 10'd1022, 8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd1018, 10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd1022, 10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd1021, 10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_WRITE,   10'd512,  10'd0,    8'h00);
    send_cmd(bbrr_pkg::OP_READ,    10'd512,  10'd1023, 8'hFF);
    idle_cmd();
  endtask

  // Mostly well-formed sequences with random content, some noise, under
  // each idle/stall mix in turn.
  task automatic test_random();
    int idle_mix [4];
    int stall_mix[4];
    int target;
    idle_mix  = '{0, 53, 0, 37};
    stall_mix = '{0, 0, 53, 37};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_mix[p];
      rsp_stall_pct   = stall_mix[p];
      target          = cmds_sent + 105;
      while (cmds_sent < target) begin
        if ($urandom_range(3) != 0)
          run_text_sequence(($urandom_range(9) == 0) ? 24 : 8);
        else
          send_noise();
      end
    end
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;
    idle_cmd();
  endtask

  // Hold the response side off for a long stretch while reads keep coming,
  // so the block fills and stalls its command input.
  task automatic test_rsp_holdoff();
    int held_cycles;
    fork
      begin
        hold_rsp    = 1'b1;
        held_cycles = 0;
        while (held_cycles < 400) begin
          @(posedge clk);
          held_cycles++;
        end
        hold_rsp = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) begin
          if (i % 3 == 1)
            send_cmd(bbrr_pkg::OP_WRITE, bbrr_pkg::index_t'($urandom_range(1023)), 10'd0,
                     bbrr_pkg::byte_t'($urandom_range(255)));
          else
            send_cmd(bbrr_pkg::OP_READ, bbrr_pkg::index_t'($urandom_range(1023)), 10'd0,
                     8'h00);
        end
      end
    join
    idle_cmd();
  endtask

  // Main sequence.
  initial begin
    int waited;
    for (int i = 0; i < bbrr_pkg::BUFFER_DEPTH; i++) buffer_mirror[i] = '0;
    rst                 = 1'b1;
    cmd_bus.valid       = 1'b0;
    cmd_bus.operation   = bbrr_pkg::OP_WRITE;
    cmd_bus.first_index = '0;
    cmd_bus.last_index  = '0;
    cmd_bus.byte_value  = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random();
    test_rsp_holdoff();

    // Drain outstanding reads, then give a trailing reverse time to finish.
    waited = 0;
    while (expected_reads.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1600) @(posedge clk);
    if (expected_reads.size() != 0)
      report_mismatch($sformatf("%0d read results never arrived", expected_reads.size()));

    $display("Ran %0d commands: %0d read results checked, %0d reverses applied.",
             cmds_sent, reads_checked, reverses_done);
    $display("Phases: directed corners, four idle/stall mixes, long response hold-off.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bbrr_pkg.sv
hw/rtl/bbrr_if.sv
hw/rtl/byte_buffer_range_reverse.sv
hw/rtl/bbrr_checker.sv
test/tb_top.sv
